@@ hdl/fxa_pkg.sv @@
// Shared types and constants for the Q24.8 fixed-point ALU.
package fxa_pkg;

    localparam int DATA_W        = 32;
    localparam int ACT_W         = 4;
    localparam int FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 4;   // power of two, pointers wrap naturally
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_GT       = 4'd4,
        ACT_LT       = 4'd5,
        ACT_GE       = 4'd6,
        ACT_LE       = 4'd7,
        ACT_EQ       = 4'd8,
        ACT_NE       = 4'd9,
        ACT_MIN      = 4'd10,
        ACT_MAX      = 4'd11,
        ACT_INC      = 4'd12,
        ACT_DEC      = 4'd13,
        ACT_FROM_INT = 4'd14,
        ACT_TO_INT   = 4'd15
    } action_t;

    typedef enum logic [1:0] {
        CLS_ALU,
        CLS_MUL,
        CLS_DIV
    } op_class_t;

    typedef struct packed {
        action_t           action;
        op_class_t         cls;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

@@ hdl/fixed_point_alu_q24_8_core.sv @@
// Top level of the signed Q24.8 fixed-point ALU core.
// One transaction in, one transaction out, in order. Each input transaction
// carries an action (add, sub, mul, div, six compares, min, max, inc, dec,
// from_int, to_int) and two raw two's complement operands; the result is a
// raw 32-bit value that wraps, a compare flag and a divide-by-zero flag.
// A new transaction is taken every cycle while the input queue is not full
// and results are taken on m_ready. An accepted transaction is written into
// the input queue, moves from there into the entry stage, then passes
// through 32 + FRAC_BITS divider stages (one quotient bit per stage) and one
// output stage. Every action flows through the full pipeline so results
// leave in order.
module fixed_point_alu_q24_8_core
    import fxa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF   // 1 to 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACT_W-1:0]         s_action,
    input  logic signed [DATA_W-1:0] s_operand_a,
    input  logic signed [DATA_W-1:0] s_operand_b,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_result,
    output logic                     m_compare_true,
    output logic                     m_divide_by_zero
);

    head_t head;   // queue head seen by the back end
    logic  pop;    // back end takes the head

    // front: classify and queue, s_ready is simply "queue not full"
    fxa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .head        (head),
        .pop         (pop)
    );

    // back: pipeline stalls only when its last stage holds an untaken result
    fxa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result         (m_result),
        .m_compare_true   (m_compare_true),
        .m_divide_by_zero (m_divide_by_zero)
    );

    // divide by zero forces a zero result
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_result == '0)
        else $error("divide by zero with nonzero result");

    // compares return a zero result
    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_true |-> m_result == '0)
        else $error("compare with nonzero result");

    // flags are exclusive
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_compare_true && m_divide_by_zero))
        else $error("both flags set");

endmodule

@@ hdl/fxa_front.sv @@
// Front end: accepts transactions, classifies the action, holds them in a short queue.
module fxa_front
    import fxa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ACT_W-1:0]  s_action,
    input  logic [DATA_W-1:0] s_operand_a,
    input  logic [DATA_W-1:0] s_operand_b,
    output head_t             head,
    input  logic              pop
);

    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    item_t             cls_item;
    logic              push;

    always_comb begin
        cls_item.action = action_t'(s_action);
        cls_item.a      = s_operand_a;
        cls_item.b      = s_operand_b;
        case (cls_item.action)
            ACT_MUL: cls_item.cls = CLS_MUL;
            ACT_DIV: cls_item.cls = CLS_DIV;
            default: cls_item.cls = CLS_ALU;
        endcase
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

endmodule

@@ hdl/fxa_back.sv @@
// Back end: execution pipeline with a one-bit-per-stage restoring divider.
module fxa_back
    import fxa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  head_t             head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_result,
    output logic              m_compare_true,
    output logic              m_divide_by_zero
);

    localparam int NUM_W = DATA_W + FRAC_BITS;   // dividend width, one stage per bit
    localparam int LAST  = NUM_W + 1;

    typedef struct packed {
        op_class_t           cls;
        logic [DATA_W-1:0]   res;
        logic                cmp;
        logic                dz;
        logic                neg;
        logic [DATA_W-1:0]   dvs;
        logic [DATA_W:0]     rem;
        logic [NUM_W-1:0]    quo;
        logic [2*DATA_W-1:0] prod;
    } stage_t;

    stage_t st_reg  [LAST+1];
    stage_t st_next [LAST+1];
    logic   v_reg   [LAST+1];
    logic   advance;

    assign advance = !(v_reg[LAST] && !m_ready);
    assign pop     = advance && head.valid;

    always_comb begin
        logic signed [DATA_W-1:0]   sa, sb, shr;
        logic signed [2*DATA_W-1:0] ps;
        logic [DATA_W-1:0]          amag;
        logic [DATA_W:0]            trial;
        logic                       qbit;
        stage_t                     s;

        // entry stage: simple ops, operand prep, multiplier
        sa   = $signed(head.item.a);
        sb   = $signed(head.item.b);
        shr  = sa >>> FRAC_BITS;
        amag = head.item.a[DATA_W-1] ? -head.item.a : head.item.a;
        st_next[0].cls  = head.item.cls;
        st_next[0].res  = '0;
        st_next[0].cmp  = 1'b0;
        st_next[0].dz   = (head.item.cls == CLS_DIV) && (head.item.b == '0);
        st_next[0].neg  = head.item.a[DATA_W-1] ^ head.item.b[DATA_W-1];
        st_next[0].dvs  = head.item.b[DATA_W-1] ? -head.item.b : head.item.b;
        st_next[0].rem  = '0;
        st_next[0].quo  = {amag, {FRAC_BITS{1'b0}}};
        st_next[0].prod = sa * sb;
        case (head.item.action)
            ACT_ADD:      st_next[0].res = head.item.a + head.item.b;
            ACT_SUB:      st_next[0].res = head.item.a - head.item.b;
            ACT_GT:       st_next[0].cmp = sa > sb;
            ACT_LT:       st_next[0].cmp = sa < sb;
            ACT_GE:       st_next[0].cmp = sa >= sb;
            ACT_LE:       st_next[0].cmp = sa <= sb;
            ACT_EQ:       st_next[0].cmp = sa == sb;
            ACT_NE:       st_next[0].cmp = sa != sb;
            ACT_MIN:      st_next[0].res = (sa < sb) ? head.item.a : head.item.b;
            ACT_MAX:      st_next[0].res = (sa > sb) ? head.item.a : head.item.b;
            ACT_INC:      st_next[0].res = head.item.a + DATA_W'(1);
            ACT_DEC:      st_next[0].res = head.item.a - DATA_W'(1);
            ACT_FROM_INT: st_next[0].res = head.item.a << FRAC_BITS;
            ACT_TO_INT:   st_next[0].res = shr;
            default:      st_next[0].res = '0;
        endcase

        // divider stages; the first one also finishes the multiply
        for (int i = 1; i <= NUM_W; i++) begin
            s     = st_reg[i-1];
            trial = {s.rem[DATA_W-1:0], s.quo[NUM_W-1]};
            qbit  = (trial >= {1'b0, s.dvs});
            st_next[i]     = s;
            st_next[i].rem = qbit ? (trial - {1'b0, s.dvs}) : trial;
            st_next[i].quo = {s.quo[NUM_W-2:0], qbit};
            ps             = $signed(s.prod) >>> FRAC_BITS;
            if (i == 1 && s.cls == CLS_MUL) begin
                st_next[i].res = ps[DATA_W-1:0];
            end
        end

        // output stage: sign the quotient, or zero it on divide by zero
        st_next[LAST] = st_reg[NUM_W];
        if (st_reg[NUM_W].cls == CLS_DIV) begin
            if (st_reg[NUM_W].dz) begin
                st_next[LAST].res = '0;
            end else if (st_reg[NUM_W].neg) begin
                st_next[LAST].res = -st_reg[NUM_W].quo[DATA_W-1:0];
            end else begin
                st_next[LAST].res = st_reg[NUM_W].quo[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAST; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (advance) begin
            v_reg[0] <= head.valid;
            for (int i = 1; i <= LAST; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i <= LAST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign m_valid          = v_reg[LAST];
    assign m_result         = st_reg[LAST].res;
    assign m_compare_true   = st_reg[LAST].cmp;
    assign m_divide_by_zero = st_reg[LAST].dz;

endmodule
